/* rtl/bctm_pkg.sv */
// Package for the block cache tag manager: command and status codes and the
// beat types of both channels. No dependencies.
`default_nettype none
package bctm_pkg;
  typedef enum logic [2:0] {
    CMD_GET = 3'd0, CMD_RELEASE = 3'd1, CMD_MARK_DIRTY = 3'd2,
    CMD_SYNC_NEXT = 3'd3, CMD_WRITE_DONE = 3'd4, CMD_FILL_FAILED = 3'd5
  } cmd_e;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_FREE = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;
  localparam logic [1:0] ST_NOT_DIRTY = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] block_number;
    logic        no_read;
    logic [7:0]  slot;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot_res;
    logic        hit;
    logic        need_read;
    logic        need_writeback;
    logic [63:0] writeback_block;
  } rsp_t;
endpackage
`default_nettype wire

/* rtl/block_cache_tag_manager_core.sv */
// Block cache tag manager: one slot table memory with a sequential scanner.
// Depends on bctm_pkg.
//
// Use: a request beat (in_valid/in_ready, payload in_data) carries one command;
// exactly one response beat (out_valid/out_ready, out_data) follows. Requests
// are handled one at a time. For slot commands (release, mark dirty, write done,
// fill failed) with an in-range slot the entry is read at acceptance, modified and,
// if valid, written back in the next cycle, then the response is loaded into the
// output register. Get and sync next scan the slot table one entry per cycle
// through the single read port, with a setup state (S_READ) before each pass. On a
// get, a miss does the tag pass and then either the free-slot pass or, with a
// full table, the unreferenced-slot pass. Sync stops at the first dirty slot.
// After reset a clearing pass writes every table entry to zero
// while in_ready is low. A stalled receiver holds the result in the output register;
// the next request is accepted once that register has been taken or is being
// taken in the same cycle.
`default_nettype none
module block_cache_tag_manager_core
  import bctm_pkg::*;
#(
  parameter int ENTRIES  = 256,
  parameter int REF_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);
  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [REF_BITS-1:0] REF_MAX = '1;

  typedef struct packed {
    logic                valid;
    logic                dirty;
    logic [REF_BITS-1:0] refs;
    logic [63:0]         tag;
  } ent_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_SCAN, S_MODIFY, S_DONE
  } state_t;

  typedef enum logic [1:0] { P_TAG, P_FREE, P_UNREF, P_DIRTY } pass_t;

  ent_t mem [ENTRIES];
  ent_t rd;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  ent_t          wr_data;
  logic [AW-1:0] rd_addr;

  state_t        state;
  pass_t         pass;
  req_t          req;
  logic [AW-1:0] idx;
  logic [CW-1:0] in_use;
  rsp_t          rsp;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd <= mem[rd_addr];
  end

  // Slot index beyond the table is reported as not valid.
  logic slot_range;
  assign slot_range = ({24'd0, in_data.slot} < 32'(ENTRIES));
  logic req_range;
  assign req_range = ({24'd0, req.slot} < 32'(ENTRIES));
  logic last;
  assign last = ({{(32-AW){1'b0}}, idx} == 32'(ENTRIES - 1));

  logic scan_cmd;
  assign scan_cmd = (in_data.cmd == CMD_GET) || (in_data.cmd == CMD_SYNC_NEXT);
  logic bad_slot_req;
  assign bad_slot_req = !slot_range && (in_data.cmd inside {CMD_RELEASE, CMD_MARK_DIRTY,
      CMD_WRITE_DONE, CMD_FILL_FAILED});

  logic scan_match;
  always_comb begin
    case (pass)
      P_TAG:   scan_match = rd.valid && rd.tag == req.block_number;
      P_FREE:  scan_match = !rd.valid;
      P_UNREF: scan_match = rd.valid && rd.refs == '0;
      default: scan_match = rd.valid && rd.dirty;
    endcase
  end

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    rd_addr = idx;
    if (state == S_IDLE) rd_addr = scan_cmd ? '0 : AW'(in_data.slot);
    if (state == S_READ) rd_addr = idx;
    // On a match the entry is read again so that it is at hand for the write back.
    if (state == S_SCAN) rd_addr = scan_match ? idx : idx + AW'(1);
  end

  always_comb begin
    wr_en = 1'b0;
    wr_addr = idx;
    wr_data = rd;
    if (state == S_CLEAR) begin
      wr_en = 1'b1;
      wr_data = '0;
    end else if (state == S_MODIFY && req.cmd == CMD_GET) begin
      wr_en = 1'b1;
      if (rsp.hit) begin
        if (rd.refs != REF_MAX) wr_data.refs = rd.refs + 1'b1;
      end else begin
        wr_data = '{valid: 1'b1, dirty: 1'b0, refs: REF_BITS'(1), tag: req.block_number};
      end
    end else if (state == S_MODIFY && req_range && rd.valid) begin
      wr_en = 1'b1;
      case (req.cmd)
        CMD_RELEASE:     if (rd.refs != '0) wr_data.refs = rd.refs - 1'b1;
        CMD_MARK_DIRTY:  wr_data.dirty = 1'b1;
        CMD_WRITE_DONE:  wr_data.dirty = 1'b0;
        CMD_FILL_FAILED: wr_data = '{valid: 1'b0, dirty: 1'b0, refs: '0, tag: rd.tag};
        default:         wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx <= '0;
      in_use <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          idx <= idx + AW'(1);
          if (last) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          req <= in_data;
          rsp <= '{status: bad_slot_req ? ST_BAD_SLOT : ST_OK, slot_res: '0, hit: 1'b0,
                   need_read: 1'b0, need_writeback: 1'b0, writeback_block: '0};
          idx <= scan_cmd ? '0 : AW'(in_data.slot);
          case (in_data.cmd)
            CMD_GET: begin pass <= P_TAG; state <= S_READ; end
            CMD_SYNC_NEXT: begin pass <= P_DIRTY; state <= S_READ; end
            CMD_RELEASE, CMD_MARK_DIRTY, CMD_WRITE_DONE, CMD_FILL_FAILED:
              state <= slot_range ? S_MODIFY : S_DONE;
            default: state <= S_DONE;
          endcase
        end
        S_READ: begin
          // Entry zero is being read; its data reaches the scanner next cycle.
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (scan_match) begin
            rsp.slot_res <= 8'(idx);
            case (pass)
              P_TAG: begin
                rsp.hit <= 1'b1;
                if (rd.refs == REF_MAX) rsp.status <= ST_BAD_SLOT;
                state <= S_MODIFY;
              end
              P_DIRTY: begin
                rsp.need_writeback <= 1'b1;
                rsp.writeback_block <= rd.tag;
                state <= S_DONE;
              end
              default: begin
                rsp.need_read <= !req.no_read;
                if (pass == P_FREE) in_use <= in_use + CW'(1);
                if (rd.dirty) begin
                  rsp.need_writeback <= 1'b1;
                  rsp.writeback_block <= rd.tag;
                end
                state <= S_MODIFY;
              end
            endcase
            idx <= idx;
          end else if (last) begin
            idx <= '0;
            case (pass)
              P_TAG: begin
                pass <= (in_use < CW'(ENTRIES)) ? P_FREE : P_UNREF;
                state <= S_READ;
              end
              P_FREE: begin pass <= P_UNREF; state <= S_READ; end
              P_UNREF: begin rsp.status <= ST_NO_FREE; state <= S_DONE; end
              default: begin rsp.status <= ST_NOT_DIRTY; state <= S_DONE; end
            endcase
          end else begin
            idx <= idx + AW'(1);
          end
        end
        S_MODIFY: begin
          // rd holds the entry at idx: the matched entry was read again, or slot read landed.
          if (req.cmd != CMD_GET) begin
            if (!rd.valid || (req.cmd == CMD_RELEASE && rd.refs == '0))
              rsp.status <= ST_BAD_SLOT;
            if (req.cmd == CMD_FILL_FAILED && rd.valid && in_use != '0)
              in_use <= in_use - CW'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_data <= rsp;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/bctm_checker.sv */
// Port-level checks for block_cache_tag_manager_core, bound into that module.
// Depends on bctm_pkg.
`default_nettype none
module bctm_checker
  import bctm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire rsp_t out_data
);
  logic busy;
  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b0;
    else if (in_valid && in_ready) busy <= 1'b1;
    else if (out_valid && out_ready) busy <= 1'b0;
  end

  // A new request may be taken in the cycle in which the open response is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    busy && !(out_valid && out_ready) |-> !in_ready)
    else $error("request accepted while one is open");
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled response changed");
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(busy)) else $error("response without request");
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |-> !out_data.need_read && !out_data.need_writeback)
    else $error("hit with fill or writeback");
endmodule

bind block_cache_tag_manager_core bctm_checker u_bctm_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
